// ===== src/aocb_pkg.sv =====
// shared constants for the alpha over color blend unit
// color lane count used by every stage of the pipeline, lane order for the output word; no dependencies
`timescale 1ns / 1ps

package aocb_pkg;

  // color lanes carried side by side through the pipeline
  localparam int NUM_COLOR = 3;
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // fields packed in the input word: top color, top alpha, bottom color, bottom alpha
  localparam int IN_FIELDS  = 8;
  // fields packed in the output word: three colors and alpha
  localparam int OUT_FIELDS = 4;

endpackage

// ===== src/alpha_over_color_blend_unit.sv =====
// over compositing of two straight-alpha RGBA colors, one word per clock unless a full chain is stalled.
// A product stage and a sum stage feed a chain of CHANNEL_BITS divider cells (aocb_div_cell).
// Top-level module; depends on aocb_pkg, aocb_prod, aocb_sum and aocb_div_cell.
`timescale 1ns / 1ps

// Composites the top color over the bottom color. With M = 2^CHANNEL_BITS - 1 standing for
// full opacity and s = M*M - (M-a_top)*(M-a_bottom), the output alpha is floor(s/M) and each
// color is floor((c_top*a_top*M + c_bottom*a_bottom*(M-a_top)) / s); when both alphas are
// zero all outputs are zero. The block takes one word per clock unless the full chain is stalled
// at the output, and holds up to CHANNEL_BITS+2 words in flight. The stages in order register the
// channel-by-alpha products, the weighted numerators, then one quotient bit per cell of the
// divider chain, whose last cell is the output register. Every stage has its own valid bit and
// advances whenever its successor is empty or moving, so a stalled output only stops the input
// once the whole chain is full.
module alpha_over_color_blend_unit #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // top_red, top_green, top_blue, top_alpha,
  // bottom_red, bottom_green, bottom_blue, bottom_alpha
  input  logic [8*CHANNEL_BITS-1:0]                     s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, zero fill to a whole byte
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]           m_axis_tdata
);

  localparam int W       = CHANNEL_BITS;
  localparam int W2      = 2 * CHANNEL_BITS;
  localparam int W3      = 3 * CHANNEL_BITS;
  localparam int NCOL    = aocb_pkg::NUM_COLOR;
  localparam int OutBits = ((aocb_pkg::OUT_FIELDS * CHANNEL_BITS + 7) / 8) * 8;

  logic [NCOL-1:0][W-1:0]    top_color, bottom_color;
  logic [W-1:0]              top_alpha, bottom_alpha;

  logic                      prod_valid, prod_ready;
  logic [NCOL-1:0][W2-1:0]   prod_top, prod_bottom;
  logic [W2-1:0]             prod_cover;
  logic [W-1:0]              inv_top_alpha;

  // divider chain taps: index 0 is the sum stage output, index W the final cell
  logic [W:0]                        chain_valid, chain_ready;
  logic [W:0][NCOL-1:0][W3-1:0]      rem_color;
  logic [W:0][W2-1:0]                divisor;
  logic [W:0][NCOL-1:0][W-1:0]       quo_color;
  logic [W:0][W-1:0]                 quo_alpha;
  logic [W:0]                        zero;

  logic [NCOL-1:0][W-1:0]            res_color;

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      top_color[c]    = s_axis_tdata[c*W +: W];
      bottom_color[c] = s_axis_tdata[(NCOL+1+c)*W +: W];
    end
  end
  assign top_alpha    = s_axis_tdata[NCOL*W +: W];
  assign bottom_alpha = s_axis_tdata[(2*NCOL+1)*W +: W];

  aocb_prod #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prod (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .top_color_i     (top_color),
    .top_alpha_i     (top_alpha),
    .bottom_color_i  (bottom_color),
    .bottom_alpha_i  (bottom_alpha),
    .out_valid_o     (prod_valid),
    .out_ready_i     (prod_ready),
    .prod_top_o      (prod_top),
    .prod_bottom_o   (prod_bottom),
    .cover_o         (prod_cover),
    .inv_top_alpha_o (inv_top_alpha)
  );

  aocb_sum #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_sum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (prod_valid),
    .in_ready_o      (prod_ready),
    .prod_top_i      (prod_top),
    .prod_bottom_i   (prod_bottom),
    .cover_i         (prod_cover),
    .inv_top_alpha_i (inv_top_alpha),
    .out_valid_o     (chain_valid[0]),
    .out_ready_i     (chain_ready[0]),
    .num_o           (rem_color[0]),
    .cover_o         (divisor[0]),
    .zero_o          (zero[0])
  );

  // alpha is coverage over M: (x + 1 + (x >> W)) >> W, exact for x up to M*M
  assign quo_alpha[0] = W'((divisor[0] + W2'(1) + (divisor[0] >> W)) >> W);
  assign quo_color[0] = '0;

  for (genvar j = 0; j < W; j++) begin : g_cell
    aocb_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .BIT         (W - 1 - j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[j]),
      .in_ready_o  (chain_ready[j]),
      .rem_color_i (rem_color[j]),
      .divisor_i   (divisor[j]),
      .quo_color_i (quo_color[j]),
      .quo_alpha_i (quo_alpha[j]),
      .zero_i      (zero[j]),
      .out_valid_o (chain_valid[j+1]),
      .out_ready_i (chain_ready[j+1]),
      .rem_color_o (rem_color[j+1]),
      .divisor_o   (divisor[j+1]),
      .quo_color_o (quo_color[j+1]),
      .quo_alpha_o (quo_alpha[j+1]),
      .zero_o      (zero[j+1])
    );
  end

  assign m_axis_tvalid  = chain_valid[W];
  assign chain_ready[W] = m_axis_tready;

  // empty coverage divides by zero in the chain, force those colors to zero
  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      res_color[c] = zero[W] ? '0 : quo_color[W][c];
    end
  end

  assign m_axis_tdata = OutBits'({quo_alpha[W],
                                  res_color[aocb_pkg::LANE_BLUE],
                                  res_color[aocb_pkg::LANE_GREEN],
                                  res_color[aocb_pkg::LANE_RED]});

endmodule

// ===== src/aocb_prod.sv =====
// first pipeline stage: per-lane channel times alpha products and the coverage term
// uses aocb_pkg for lane count
`timescale 1ns / 1ps

module aocb_prod #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [aocb_pkg::NUM_COLOR-1:0][CHANNEL_BITS-1:0]      top_color_i,
  input  logic [CHANNEL_BITS-1:0]                               top_alpha_i,
  input  logic [aocb_pkg::NUM_COLOR-1:0][CHANNEL_BITS-1:0]      bottom_color_i,
  input  logic [CHANNEL_BITS-1:0]                               bottom_alpha_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [aocb_pkg::NUM_COLOR-1:0][2*CHANNEL_BITS-1:0]    prod_top_o,
  output logic [aocb_pkg::NUM_COLOR-1:0][2*CHANNEL_BITS-1:0]    prod_bottom_o,
  output logic [2*CHANNEL_BITS-1:0]                             cover_o,
  output logic [CHANNEL_BITS-1:0]                               inv_top_alpha_o
);

  localparam int W  = CHANNEL_BITS;
  localparam int W2 = 2 * CHANNEL_BITS;
  localparam logic [W-1:0]  ChanMax = {W{1'b1}};
  localparam logic [W2-1:0] MaxSq   = W2'(ChanMax) * W2'(ChanMax);

  logic                                          valid_q;
  logic [aocb_pkg::NUM_COLOR-1:0][W2-1:0]        prod_top_d, prod_top_q;
  logic [aocb_pkg::NUM_COLOR-1:0][W2-1:0]        prod_bottom_d, prod_bottom_q;
  logic [W2-1:0]                                 cover_d, cover_q;
  logic [W-1:0]                                  inv_top_d, inv_top_q;
  logic [W-1:0]                                  inv_bottom;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    inv_top_d  = ChanMax - top_alpha_i;
    inv_bottom = ChanMax - bottom_alpha_i;
    // combined coverage M*M - (M-a1)*(M-a2)
    cover_d    = MaxSq - W2'(inv_top_d) * W2'(inv_bottom);
    for (int c = 0; c < aocb_pkg::NUM_COLOR; c++) begin
      prod_top_d[c]    = W2'(top_color_i[c]) * W2'(top_alpha_i);
      prod_bottom_d[c] = W2'(bottom_color_i[c]) * W2'(bottom_alpha_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_top_q    <= prod_top_d;
      prod_bottom_q <= prod_bottom_d;
      cover_q       <= cover_d;
      inv_top_q     <= inv_top_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign prod_top_o      = prod_top_q;
  assign prod_bottom_o   = prod_bottom_q;
  assign cover_o         = cover_q;
  assign inv_top_alpha_o = inv_top_q;

endmodule

// ===== src/aocb_sum.sv =====
// second pipeline stage: weighted numerator per color lane and the empty-coverage flag
// uses aocb_pkg for lane count
`timescale 1ns / 1ps

module aocb_sum #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [aocb_pkg::NUM_COLOR-1:0][2*CHANNEL_BITS-1:0]    prod_top_i,
  input  logic [aocb_pkg::NUM_COLOR-1:0][2*CHANNEL_BITS-1:0]    prod_bottom_i,
  input  logic [2*CHANNEL_BITS-1:0]                             cover_i,
  input  logic [CHANNEL_BITS-1:0]                               inv_top_alpha_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [aocb_pkg::NUM_COLOR-1:0][3*CHANNEL_BITS-1:0]    num_o,
  output logic [2*CHANNEL_BITS-1:0]                             cover_o,
  output logic                                                  zero_o
);

  localparam int W  = CHANNEL_BITS;
  localparam int W3 = 3 * CHANNEL_BITS;

  logic                                          valid_q;
  logic [aocb_pkg::NUM_COLOR-1:0][W3-1:0]        num_d, num_q;
  logic [2*W-1:0]                                cover_q;
  logic                                          zero_d, zero_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int c = 0; c < aocb_pkg::NUM_COLOR; c++) begin
      // c1*a1*M as a shift and subtract, plus c2*a2*(M-a1)
      num_d[c] = ({prod_top_i[c], {W{1'b0}}} - W3'(prod_top_i[c]))
               + W3'(prod_bottom_i[c]) * W3'(inv_top_alpha_i);
    end
    zero_d = (cover_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      num_q   <= num_d;
      cover_q <= cover_i;
      zero_q  <= zero_d;
    end
  end

  assign out_valid_o = valid_q;
  assign num_o       = num_q;
  assign cover_o     = cover_q;
  assign zero_o      = zero_q;

endmodule

// ===== src/aocb_div_cell.sv =====
// one cell of the divider chain: settles quotient bit BIT for every color lane
// colors divide by the coverage term, alpha rides along unchanged; uses aocb_pkg
`timescale 1ns / 1ps

module aocb_div_cell #(
  parameter int CHANNEL_BITS = 8,
  parameter int BIT          = 0
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [aocb_pkg::NUM_COLOR-1:0][3*CHANNEL_BITS-1:0]    rem_color_i,
  input  logic [2*CHANNEL_BITS-1:0]                             divisor_i,
  input  logic [aocb_pkg::NUM_COLOR-1:0][CHANNEL_BITS-1:0]      quo_color_i,
  input  logic [CHANNEL_BITS-1:0]                               quo_alpha_i,
  input  logic                                                  zero_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [aocb_pkg::NUM_COLOR-1:0][3*CHANNEL_BITS-1:0]    rem_color_o,
  output logic [2*CHANNEL_BITS-1:0]                             divisor_o,
  output logic [aocb_pkg::NUM_COLOR-1:0][CHANNEL_BITS-1:0]      quo_color_o,
  output logic [CHANNEL_BITS-1:0]                               quo_alpha_o,
  output logic                                                  zero_o
);

  localparam int W  = CHANNEL_BITS;
  localparam int W2 = 2 * CHANNEL_BITS;
  localparam int W3 = 3 * CHANNEL_BITS;

  logic                                          valid_q;
  logic [aocb_pkg::NUM_COLOR-1:0][W3-1:0]        rem_color_d, rem_color_q;
  logic [W2-1:0]                                 divisor_q;
  logic [aocb_pkg::NUM_COLOR-1:0][W-1:0]         quo_color_d, quo_color_q;
  logic [W-1:0]                                  quo_alpha_q;
  logic                                          zero_q;
  logic [W3-1:0]                                 color_step;

  assign in_ready_o = !valid_q || out_ready_i;

  // restoring step against the divisor shifted up to this bit position
  always_comb begin
    color_step  = W3'(divisor_i) << BIT;
    rem_color_d = rem_color_i;
    quo_color_d = quo_color_i;
    for (int c = 0; c < aocb_pkg::NUM_COLOR; c++) begin
      if (rem_color_i[c] >= color_step) begin
        rem_color_d[c]      = rem_color_i[c] - color_step;
        quo_color_d[c][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_color_q <= rem_color_d;
      divisor_q   <= divisor_i;
      quo_color_q <= quo_color_d;
      quo_alpha_q <= quo_alpha_i;
      zero_q      <= zero_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_color_o = rem_color_q;
  assign divisor_o   = divisor_q;
  assign quo_color_o = quo_color_q;
  assign quo_alpha_o = quo_alpha_q;
  assign zero_o      = zero_q;

endmodule
